[src/trfb_pkg.sv]
// Shared types and constants for the target report frame builder.
package trfb_pkg;

    localparam int PC_W  = 5;
    localparam int CNT_W = 3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] HDR_MAGIC0  = 8'h4B;
    localparam logic [7:0] HDR_MAGIC1  = 8'h47;
    localparam logic [7:0] HDR_MAGIC2  = 8'h4E;
    localparam logic [7:0] HDR_VERSION = 8'h01;
    localparam logic [7:0] HDR_TYPE    = 8'h01;

    // program addresses that the sequencer jumps to or tests
    localparam logic [PC_W-1:0] PC_CRC_LO = 5'd16;

    // register index on the APB port
    localparam logic REG_NODE_ID = 1'b0;

    typedef enum logic [4:0] {
        SRC_MAGIC0,
        SRC_MAGIC1,
        SRC_MAGIC2,
        SRC_VERSION,
        SRC_TYPE,
        SRC_ZERO,
        SRC_SEQ_LO,
        SRC_SEQ_HI,
        SRC_NODE0,
        SRC_NODE1,
        SRC_NODE2,
        SRC_NODE3,
        SRC_PLEN_LO,
        SRC_PLEN_HI,
        SRC_COUNT,
        SRC_TARGET,
        SRC_CRC_LO,
        SRC_CRC_HI
    } src_t;

    typedef enum logic [1:0] {
        OP_NEXT,
        OP_SKIP_IF_EMPTY,
        OP_TARGET_LOOP,
        OP_END
    } op_t;

    typedef struct packed {
        src_t            src;
        op_t             op;
        logic            crc_en;
        logic            last;
        logic [PC_W-1:0] jump;
    } ucw_t;

    typedef struct packed {
        logic wr;
        logic clr;
    } st_ctl_t;

endpackage

[src/trfb_rom.sv]
// Microcode ROM: one control word per frame-building step.
module trfb_rom (
    input  logic [trfb_pkg::PC_W-1:0] pc,
    output trfb_pkg::ucw_t            cw
);
    import trfb_pkg::*;

    function automatic ucw_t mk(src_t s, op_t o, logic c, logic l, logic [PC_W-1:0] j);
        ucw_t w;
        w.src    = s;
        w.op     = o;
        w.crc_en = c;
        w.last   = l;
        w.jump   = j;
        return w;
    endfunction

    always_comb
    begin
        unique case (pc)
            5'd0:    cw = mk(SRC_MAGIC0,  OP_NEXT, 1'b1, 1'b0, '0);
            5'd1:    cw = mk(SRC_MAGIC1,  OP_NEXT, 1'b1, 1'b0, '0);
            5'd2:    cw = mk(SRC_MAGIC2,  OP_NEXT, 1'b1, 1'b0, '0);
            5'd3:    cw = mk(SRC_VERSION, OP_NEXT, 1'b1, 1'b0, '0);
            5'd4:    cw = mk(SRC_TYPE,    OP_NEXT, 1'b1, 1'b0, '0);
            5'd5:    cw = mk(SRC_ZERO,    OP_NEXT, 1'b1, 1'b0, '0);
            5'd6:    cw = mk(SRC_SEQ_LO,  OP_NEXT, 1'b1, 1'b0, '0);
            5'd7:    cw = mk(SRC_SEQ_HI,  OP_NEXT, 1'b1, 1'b0, '0);
            5'd8:    cw = mk(SRC_NODE0,   OP_NEXT, 1'b1, 1'b0, '0);
            5'd9:    cw = mk(SRC_NODE1,   OP_NEXT, 1'b1, 1'b0, '0);
            5'd10:   cw = mk(SRC_NODE2,   OP_NEXT, 1'b1, 1'b0, '0);
            5'd11:   cw = mk(SRC_NODE3,   OP_NEXT, 1'b1, 1'b0, '0);
            5'd12:   cw = mk(SRC_PLEN_LO, OP_NEXT, 1'b1, 1'b0, '0);
            5'd13:   cw = mk(SRC_PLEN_HI, OP_NEXT, 1'b1, 1'b0, '0);
            5'd14:   cw = mk(SRC_COUNT,   OP_SKIP_IF_EMPTY, 1'b1, 1'b0, PC_CRC_LO);
            5'd15:   cw = mk(SRC_TARGET,  OP_TARGET_LOOP, 1'b1, 1'b0, '0);
            5'd16:   cw = mk(SRC_CRC_LO,  OP_NEXT, 1'b0, 1'b0, '0);
            5'd17:   cw = mk(SRC_CRC_HI,  OP_END,  1'b0, 1'b1, '0);
            default: cw = mk(SRC_ZERO,    OP_END,  1'b0, 1'b1, '0);
        endcase
    end

endmodule

[src/trfb_crc16.sv]
// CRC-16/CCITT-FALSE accumulator, one byte per cycle while en is high.
module trfb_crc16 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        init,
    input  logic        en,
    input  logic [7:0]  data,
    output logic [15:0] crc
);
    import trfb_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    // MSB first, no reflection
    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        priority if (init)
            crc_next = CRC_INIT;
        else if (en)
            crc_next = crc_step(crc_reg, data);
        else
            crc_next = crc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

[src/trfb_store.sv]
// Target store: fill count and packed target words with byte read-out.
module trfb_store #(
    parameter int MAX_SLOTS = 3,
    parameter int IDX_W     = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  trfb_pkg::st_ctl_t          ctl,
    input  logic [63:0]                wdata,
    input  logic [IDX_W-1:0]           rd_idx,
    input  logic [2:0]                 rd_byte_sel,
    output logic [trfb_pkg::CNT_W-1:0] count,
    output logic [7:0]                 rd_byte
);
    import trfb_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [63:0]      store_reg [MAX_SLOTS];
    logic             room;

    assign room = (count_reg < CNT_W'(MAX_SLOTS));

    always_comb
    begin
        priority if (ctl.clr)
            count_next = '0;
        else if (ctl.wr && room)
            count_next = count_reg + 1'b1;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr && room && !ctl.clr)
            store_reg[count_reg[IDX_W-1:0]] <= wdata;
    end

    assign rd_byte = store_reg[rd_idx][{rd_byte_sel, 3'b000} +: 8];
    assign count   = count_reg;

endmodule

[src/target_report_frame_builder.sv]
// Top level of the target report frame builder: sequencer, config port, output word register.
//
// Usage:
//   Input channel: one target slot per word, accepted on a rising edge with start high
//   and busy low. Valid slots go into the target store until it holds MAX_SLOTS of them;
//   further valid slots are dropped.
//   A slot with last_slot high starts a frame. busy rises right after the accepting edge
//   and the frame goes out one byte word per cycle on out_byte, each marked by a one-cycle
//   strobe: 14 header bytes, the count byte, 8 bytes per stored target, then the CRC
//   low/high. frame_end marks the final CRC byte. The accepting edge sets the sequencer
//   running, and the first byte then reaches the ports through the output word register;
//   busy stays high for the whole microcode program, which emits one byte per step.
//   A slot that is not last gives no output and does not raise busy.
//   busy drops in the cycle that shows the last byte, so the next slot may be taken then.
//   The receiver cannot stall: each output word is valid for exactly one cycle.
//   Config: APB write to offset 0 sets node_id; write only while idle.
//   Reset clears sequence, target count and sequencer, sets the CRC to its initial value; node_id resets to zero.
module target_report_frame_builder #(
    parameter int MAX_SLOTS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               slot_valid,
    input  logic signed [15:0] x_mm,
    input  logic signed [15:0] y_mm,
    input  logic signed [15:0] velocity,
    input  logic [15:0]        resolution_mm,
    input  logic               last_slot,
    output logic               strobe,
    output logic [7:0]         out_byte,
    output logic               frame_end,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import trfb_pkg::*;

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    // sequencer state
    logic             running_reg, running_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [IDX_W-1:0] tgt_idx_reg, tgt_idx_next;
    logic [2:0]       byte_idx_reg, byte_idx_next;
    logic [15:0]      seq_reg, seq_next;
    logic [31:0]      node_id_reg, node_id_next;

    // output word register
    logic             strobe_reg, strobe_next;
    logic             frame_end_reg, frame_end_next;
    logic [7:0]       out_byte_reg, out_byte_next;

    logic             accept;
    logic             cfg_wr;
    ucw_t             cw;
    st_ctl_t          st_ctl;
    logic [CNT_W-1:0] count;
    logic [7:0]       tgt_byte;
    logic [15:0]      crc;
    logic [15:0]      plen;
    logic [7:0]       cur_byte;
    logic             crc_init;
    logic             crc_en;

    assign accept   = start && !running_reg;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign plen     = 16'({count, 3'b000}) + 16'd1;
    assign crc_init = accept && last_slot;
    assign crc_en   = running_reg && cw.crc_en;

    trfb_rom u_rom (
        .pc (pc_reg),
        .cw (cw)
    );

    trfb_crc16 u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .init  (crc_init),
        .en    (crc_en),
        .data  (cur_byte),
        .crc   (crc)
    );

    trfb_store #(
        .MAX_SLOTS (MAX_SLOTS),
        .IDX_W     (IDX_W)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (st_ctl),
        .wdata       ({resolution_mm, velocity, y_mm, x_mm}),
        .rd_idx      (tgt_idx_reg),
        .rd_byte_sel (byte_idx_reg),
        .count       (count),
        .rd_byte     (tgt_byte)
    );

    // byte source mux driven by the control word
    always_comb
    begin
        unique case (cw.src)
            SRC_MAGIC0:  cur_byte = HDR_MAGIC0;
            SRC_MAGIC1:  cur_byte = HDR_MAGIC1;
            SRC_MAGIC2:  cur_byte = HDR_MAGIC2;
            SRC_VERSION: cur_byte = HDR_VERSION;
            SRC_TYPE:    cur_byte = HDR_TYPE;
            SRC_ZERO:    cur_byte = 8'h00;
            SRC_SEQ_LO:  cur_byte = seq_reg[7:0];
            SRC_SEQ_HI:  cur_byte = seq_reg[15:8];
            SRC_NODE0:   cur_byte = node_id_reg[7:0];
            SRC_NODE1:   cur_byte = node_id_reg[15:8];
            SRC_NODE2:   cur_byte = node_id_reg[23:16];
            SRC_NODE3:   cur_byte = node_id_reg[31:24];
            SRC_PLEN_LO: cur_byte = plen[7:0];
            SRC_PLEN_HI: cur_byte = plen[15:8];
            SRC_COUNT:   cur_byte = 8'(count);
            SRC_TARGET:  cur_byte = tgt_byte;
            SRC_CRC_LO:  cur_byte = crc[7:0];
            SRC_CRC_HI:  cur_byte = crc[15:8];
            default:     cur_byte = 8'h00;
        endcase
    end

    // step counter, loop counters and jumps
    always_comb
    begin
        running_next   = running_reg;
        pc_next        = pc_reg;
        tgt_idx_next   = tgt_idx_reg;
        byte_idx_next  = byte_idx_reg;
        seq_next       = seq_reg;
        strobe_next    = 1'b0;
        frame_end_next = 1'b0;
        out_byte_next  = cur_byte;
        st_ctl.wr      = accept && slot_valid;
        st_ctl.clr     = 1'b0;

        if (running_reg)
        begin
            strobe_next    = 1'b1;
            frame_end_next = cw.last;
            unique case (cw.op)
                OP_NEXT:
                    pc_next = pc_reg + 1'b1;
                OP_SKIP_IF_EMPTY:
                    pc_next = (count == '0) ? cw.jump : pc_reg + 1'b1;
                OP_TARGET_LOOP:
                begin
                    byte_idx_next = byte_idx_reg + 1'b1;
                    if (byte_idx_reg == 3'd7)
                    begin
                        // end of one target word: next target or leave the loop
                        if ((CNT_W'(tgt_idx_reg) + 1'b1) == count)
                            pc_next = pc_reg + 1'b1;
                        else
                            tgt_idx_next = tgt_idx_reg + 1'b1;
                    end
                end
                OP_END:
                begin
                    running_next = 1'b0;
                    seq_next     = seq_reg + 1'b1;
                    st_ctl.clr   = 1'b1;
                end
                default:
                    running_next = 1'b0;
            endcase
        end
        else if (accept && last_slot)
        begin
            running_next  = 1'b1;
            pc_next       = '0;
            tgt_idx_next  = '0;
            byte_idx_next = '0;
        end
    end

    always_comb
    begin
        node_id_next = node_id_reg;
        if (cfg_wr && (paddr[2] == REG_NODE_ID))
            node_id_next = pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            pc_reg        <= '0;
            tgt_idx_reg   <= '0;
            byte_idx_reg  <= '0;
            seq_reg       <= '0;
            node_id_reg   <= '0;
            strobe_reg    <= 1'b0;
            frame_end_reg <= 1'b0;
        end
        else
        begin
            running_reg   <= running_next;
            pc_reg        <= pc_next;
            tgt_idx_reg   <= tgt_idx_next;
            byte_idx_reg  <= byte_idx_next;
            seq_reg       <= seq_next;
            node_id_reg   <= node_id_next;
            strobe_reg    <= strobe_next;
            frame_end_reg <= frame_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

    assign busy      = running_reg;
    assign strobe    = strobe_reg;
    assign frame_end = frame_end_reg;
    assign out_byte  = out_byte_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_NODE_ID) ? node_id_reg : 32'd0;

    // frame_end only ever tags an emitted word
    a_end_strobed: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |-> strobe)
        else $error("frame_end without strobe");

    // every output word comes from a busy cycle
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("strobe outside a frame");

    // the sequencer stops exactly on the last CRC byte
    a_fall_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> frame_end)
        else $error("frame stopped without frame_end");

    // a gap follows each frame: frame_end is never directly followed by a strobe
    a_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> !strobe)
        else $error("output word right after frame_end");

endmodule
